FILE: hw/rtl/rsa_pkg.sv
// ---------------------------------------------------------------------------
// rsa_pkg
// Shared types and codes of the reference-counted slot allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int unsigned NumSlotsDef  = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned GroupBits    = 16;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_GET    = 2'd1,
    CMD_PUT    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_id;
    logic        inherited;
    logic        freed;
    logic [15:0] count_after;
  } rsp_t;

  // classified request as held in the queue
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slot;
    logic       in_range;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rsa_front.sv
// ---------------------------------------------------------------------------
// rsa_front
// Takes a request, checks the slot id against the table size and hands the
// classified request to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rsa_front #(
  parameter int unsigned NUM_SLOTS = rsa_pkg::NumSlotsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rsa_pkg::req_t req_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output rsa_pkg::entry_t    q_entry_o
);
  import rsa_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q;
  logic   accept;

  assign q_push_o  = valid_q & ~q_full_i;
  assign busy      = valid_q & q_full_i;
  assign accept    = start & ~busy;
  assign q_entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    if (q_push_o) valid_d = 1'b0;
    if (accept)   valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.cmd      <= req_i.cmd;
      entry_q.slot     <= req_i.slot;
      entry_q.in_range <= ({1'b0, req_i.slot} < 9'(NUM_SLOTS));
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_queue.sv
// ---------------------------------------------------------------------------
// rsa_queue
// Two-entry request queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module rsa_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rsa_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output rsa_pkg::entry_t      entry_o
);
  import rsa_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push & ~do_pop) cnt_d = cnt_q + 2'd1;
    if (do_pop & ~do_push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_back.sv
// ---------------------------------------------------------------------------
// rsa_back
// Executes create, get and put against the slot table and drives the result.
// ---------------------------------------------------------------------------
`default_nettype none

module rsa_back #(
  parameter int unsigned NUM_SLOTS  = rsa_pkg::NumSlotsDef,
  parameter int unsigned COUNT_BITS = rsa_pkg::CountBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire rsa_pkg::entry_t q_entry_i,
  output logic                 q_pop_o,
  output logic                 rsp_valid_o,
  output rsa_pkg::rsp_t        rsp_o
);
  import rsa_pkg::*;

  localparam int unsigned IdxW  = $clog2(NUM_SLOTS);
  localparam int unsigned NumGr = (NUM_SLOTS + GroupBits - 1) / GroupBits;
  localparam int unsigned FreeW = NumGr * GroupBits;
  localparam int unsigned FndW  = IdxW + 4;
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [NUM_SLOTS-1:0]  used_q;
  logic [COUNT_BITS-1:0] cnt0_q;
  logic [COUNT_BITS-1:0] cnt_mem [NUM_SLOTS];
  logic [COUNT_BITS-1:0] rdata_q;
  entry_t                ent_q;
  rsp_t                  rsp_q, rsp_d;
  logic                  rsp_valid_q;

  logic [FreeW-1:0] free_vec;
  logic             grp_any_q [NumGr];
  logic [3:0]       grp_idx_q [NumGr];

  logic                  any_free;
  logic [IdxW-1:0]       found;
  logic [FndW-1:0]       found_full;
  logic [IdxW-1:0]       idx;
  logic                  used;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  cnt0_we;
  logic                  used_set, used_clr;
  logic                  exec;
  logic [COUNT_BITS+15:0] cnt_ext;
  logic [IdxW+7:0]        found_ext;

  function automatic logic [3:0] lowest16(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  assign exec    = (state_q == S_EXEC);
  assign q_pop_o = (state_q == S_IDLE) & q_valid_i;

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = q_pop_o ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // free map, slot 0 and padding never free
  always_comb begin
    free_vec = '0;
    for (int i = 1; i < NUM_SLOTS; i++) begin
      free_vec[i] = ~used_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NumGr; g++) begin
      grp_any_q[g] <= |free_vec[g*GroupBits +: GroupBits];
      grp_idx_q[g] <= lowest16(free_vec[g*GroupBits +: GroupBits]);
    end
  end

  always_comb begin
    any_free   = 1'b0;
    found_full = '0;
    for (int g = NumGr - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        any_free   = 1'b1;
        found_full = (FndW'(g) << 4) | FndW'(grp_idx_q[g]);
      end
    end
  end
  assign found = found_full[IdxW-1:0];

  assign idx  = ent_q.slot[IdxW-1:0];
  assign used = ent_q.in_range & used_q[idx];
  assign cur  = used ? ((idx == '0) ? cnt0_q : rdata_q) : '0;

  always_comb begin
    rsp_d     = '0;
    rsp_d.slot_id = ent_q.slot;
    new_cnt   = cur;
    wr_en     = 1'b0;
    cnt0_we   = 1'b0;
    wr_addr   = idx;
    wr_data   = cur;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    found_ext = {8'b0, found};
    unique case (ent_q.cmd)
      CMD_CREATE: begin
        if (!any_free) begin
          rsp_d.status  = ST_FULL;
          rsp_d.slot_id = '0;
        end else begin
          rsp_d.status    = ST_DONE;
          rsp_d.slot_id   = found_ext[7:0];
          rsp_d.inherited = used;
          new_cnt         = COUNT_BITS'(1);
          wr_en           = 1'b1;
          wr_addr         = found;
          wr_data         = new_cnt;
          used_set        = 1'b1;
        end
      end
      CMD_GET: begin
        if (!used) begin
          rsp_d.status = ST_IGNORED;
        end else begin
          rsp_d.status = ST_DONE;
          if (cur != CntMax) new_cnt = cur + COUNT_BITS'(1);
          wr_data = new_cnt;
          if (idx == '0) cnt0_we = 1'b1;
          else           wr_en   = 1'b1;
        end
      end
      CMD_PUT: begin
        if (!used || (ent_q.slot == 8'd0)) begin
          rsp_d.status = ST_IGNORED;
        end else if (cur <= COUNT_BITS'(1)) begin
          rsp_d.status = ST_DONE;
          rsp_d.freed  = 1'b1;
          new_cnt      = '0;
          used_clr     = 1'b1;
        end else begin
          rsp_d.status = ST_DONE;
          new_cnt      = cur - COUNT_BITS'(1);
          wr_data      = new_cnt;
          wr_en        = 1'b1;
        end
      end
      default: begin
        rsp_d.status = ST_IGNORED;
        new_cnt      = '0;
      end
    endcase
    if (rsp_d.status == ST_FULL) new_cnt = '0;
    cnt_ext           = {16'b0, new_cnt};
    rsp_d.count_after = cnt_ext[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= NUM_SLOTS'(1);
      cnt0_q      <= COUNT_BITS'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= exec;
      if (exec && used_set) used_q[found] <= 1'b1;
      if (exec && used_clr) used_q[idx]   <= 1'b0;
      if (exec && cnt0_we)  cnt0_q        <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && wr_en) cnt_mem[wr_addr] <= wr_data;
    if (q_pop_o) begin
      rdata_q <= cnt_mem[q_entry_i.slot[IdxW-1:0]];
      ent_q   <= q_entry_i;
    end
    if (exec) rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/refcounted_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// refcounted_slot_allocator_unit
// Slot table with used flags and saturating reference counts.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// one result, shown on rsp_o for a single cycle with rsp_valid_o high; the
// receiver cannot hold it off and must take it then. A request is checked and
// queued by the front, then executed by the back: the pop from the queue
// registers the read of the count memory, and in S_EXEC the count update and
// the lowest-free search are done and the result is registered. The back pops
// no new request until it has returned to S_IDLE.
// busy rises only while the two-entry queue is full.
`default_nettype none

module refcounted_slot_allocator_unit #(
  parameter int unsigned NUM_SLOTS  = rsa_pkg::NumSlotsDef,
  parameter int unsigned COUNT_BITS = rsa_pkg::CountBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rsa_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output rsa_pkg::rsp_t      rsp_o
);
  import rsa_pkg::*;

  logic   q_full, q_push, q_valid, q_pop;
  entry_t push_entry, head_entry;

  rsa_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (push_entry)
  );

  rsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  rsa_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the reference-counted slot allocator.
// ---------------------------------------------------------------------------
// Requests come from a queue filled at time zero and are presented at the
// falling edge. Each accepted request is run through a local copy of the
// slot table, and the expected result is queued. Every result strobe is
// checked field by field against the oldest expected result. The stimulus
// is a directed opening, a back-to-back run of gets on one slot, then
// random create-heavy and put-heavy bursts.
`default_nettype none

module testbench;
  import rsa_pkg::*;

  localparam int unsigned NSlots  = rsa_pkg::NumSlotsDef;
  localparam int unsigned CntBits = rsa_pkg::CountBitsDef;
  localparam bit [CntBits-1:0] CntMax = '1;
  localparam logic [1:0] CmdBad = 2'd3;
  localparam int unsigned IdleLimit = 2000;

  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } slot_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  slot_req_t   pending_q[$];
  rsp_t        due_q[$];
  bit          tbl_used[NSlots];
  bit [CntBits-1:0] tbl_count[NSlots];
  bit          req_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned idle_cnt = 0;
  int unsigned errors = 0;

  refcounted_slot_allocator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rsp_t apply_slot_op(input req_t r);
    rsp_t        o;
    int unsigned s;
    int unsigned free_idx;
    bit          in_rng;
    bit          in_use;
    o = '0;
    s = 32'(r.slot);
    o.slot_id = r.slot;
    in_rng = s < NSlots;
    in_use = in_rng ? tbl_used[s] : 1'b0;
    case (r.cmd)
      CMD_CREATE: begin
        free_idx = 0;
        for (int i = NSlots - 1; i >= 1; i--) begin
          if (!tbl_used[i]) free_idx = i;
        end
        if (free_idx == 0) begin
          o.status  = ST_FULL;
          o.slot_id = '0;
        end else begin
          tbl_used[free_idx]  = 1'b1;
          tbl_count[free_idx] = CntBits'(1);
          o.status      = ST_DONE;
          o.slot_id     = 8'(free_idx);
          o.inherited   = in_use;
          o.count_after = 16'd1;
        end
      end
      CMD_GET: begin
        if (!in_use) begin
          o.status = ST_IGNORED;
          if (in_rng) o.count_after = 16'(tbl_count[s]);
        end else begin
          if (tbl_count[s] != CntMax) tbl_count[s] = tbl_count[s] + 1'b1;
          o.status      = ST_DONE;
          o.count_after = 16'(tbl_count[s]);
        end
      end
      CMD_PUT: begin
        if (!in_use || s == 0) begin
          o.status = ST_IGNORED;
          if (in_rng) o.count_after = 16'(tbl_count[s]);
        end else if (tbl_count[s] <= 1) begin
          tbl_count[s] = '0;
          tbl_used[s]  = 1'b0;
          o.status = ST_DONE;
          o.freed  = 1'b1;
        end else begin
          tbl_count[s]  = tbl_count[s] - 1'b1;
          o.status      = ST_DONE;
          o.count_after = 16'(tbl_count[s]);
        end
      end
      default: begin
        o.status = ST_IGNORED;
      end
    endcase
    return o;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: %s expected %0d got %0d", fname, want, got);
      end
    end
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
      idle_cnt  <= 0;
    end else begin
      req_taken <= start && !busy;
      if (start && !busy) begin
        due_q.push_back(apply_slot_op(req_i));
      end
      if (rsp_valid_o) begin
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result, slot_id %0d", rsp_o.slot_id);
        end else begin
          want = due_q.pop_front();
          check_field("status", want.status, rsp_o.status);
          check_field("slot_id", want.slot_id, rsp_o.slot_id);
          check_field("inherited", want.inherited, rsp_o.inherited);
          check_field("freed", want.freed, rsp_o.freed);
          check_field("count_after", want.count_after, rsp_o.count_after);
        end
      end
      if ((start && !busy) || rsp_valid_o) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // request still waiting
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() != 0 &&
                 !(pending_q[0].drain && due_q.size() != 0)) begin
      start    <= 1'b1;
      req_i    <= pending_q[0].req;
      gap_left <= pending_q[0].gap;
      void'(pending_q.pop_front());
    end else begin
      start <= 1'b0;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(input logic [1:0] cmd, input int unsigned slot,
                         input int unsigned gap, input bit drain);
    slot_req_t item;
    item.req.cmd  = cmd;
    item.req.slot = 8'(slot);
    item.gap      = gap;
    item.drain    = drain;
    pending_q.push_back(item);
  endtask

  task automatic add_random_req(input bit create_heavy, input bit drain);
    int unsigned r;
    int unsigned slot;
    r = $urandom_range(0, 99);
    slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    if (r < (create_heavy ? 50 : 15)) begin
      add_req(CMD_CREATE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 17),
              pick_gap(), drain);
    end else if (r < (create_heavy ? 70 : 35)) begin
      add_req(CMD_GET, slot, pick_gap(), drain);
    end else if (r < 92) begin
      add_req(CMD_PUT, slot, pick_gap(), drain);
    end else begin
      add_req(CmdBad, $urandom_range(0, 255), pick_gap(), drain);
    end
  endtask

  initial begin
    for (int i = 0; i < NSlots; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_count[i] = '0;
    end
    tbl_used[0]  = 1'b1;
    tbl_count[0] = CntBits'(1);

    // directed opening
    add_req(CMD_CREATE, 0, pick_gap(), 1'b0);
    add_req(CMD_CREATE, 255, pick_gap(), 1'b0);
    add_req(CMD_CREATE, 5, pick_gap(), 1'b0);
    add_req(CMD_CREATE, 4, pick_gap(), 1'b0);   // new slot is not its own parent
    add_req(CMD_GET, 1, pick_gap(), 1'b0);
    add_req(CMD_PUT, 1, pick_gap(), 1'b0);
    add_req(CMD_PUT, 1, pick_gap(), 1'b0);      // frees slot 1
    add_req(CMD_PUT, 1, pick_gap(), 1'b0);      // now unused
    add_req(CMD_GET, 16, pick_gap(), 1'b0);
    add_req(CMD_PUT, 200, pick_gap(), 1'b0);
    add_req(CMD_PUT, 0, pick_gap(), 1'b0);
    add_req(CMD_GET, 0, pick_gap(), 1'b0);
    add_req(CmdBad, 8'hAA, pick_gap(), 1'b0);
    for (int i = 0; i < NSlots - 4; i++) add_req(CMD_CREATE, i, pick_gap(), 1'b0);
    add_req(CMD_CREATE, 3, pick_gap(), 1'b0);   // table full

    // back-to-back gets on slot 2
    for (int i = 0; i < 24; i++) add_req(CMD_GET, 2, 0, i == 0);
    for (int i = 0; i < 3; i++) add_req(CMD_PUT, 2, pick_gap(), 1'b0);

    // random bursts, alternating fill and drain bias
    for (int b = 0; b < 20; b++) begin
      for (int i = 0; i < 100; i++) add_random_req(b[0], i == 0);
    end

    repeat (3) @(posedge clk_i);
    #2 rst_ni = 1'b1;

    while (pending_q.size() != 0 || start || due_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (due_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
